[hw/rtl/pgalloc_pkg.sv]
// Shared constants, codes and beat types of the page allocator.
package pgalloc_pkg;

    localparam int MAX_PAGES   = 4096;
    localparam int STACK_DEPTH = 256;
    localparam int PG_W        = 12;
    localparam int CNT_W       = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W      = $clog2(MAX_PAGES);
    localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SP_AW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic [PG_W-1:0]   t_page;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [TOP_W-1:0]  t_top;
    typedef logic [SP_AW-1:0]  t_sp;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REBUILD = 2'd2,
        CMD_CHECK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_PAGE      = 2'd1,
        ST_NO_SPACE     = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd  cmd;
        t_page page_number;
    } t_in_beat;

    typedef struct packed {
        t_page   result_page;
        logic    grew;
        t_status status;
    } t_out_beat;

endpackage

[hw/rtl/pgalloc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hw/rtl/page_allocator_bitmap_stack.sv]
// Page allocator: busy bitmap and free-page stack kept in RAM, with a command sequencer.
// Allocate, free and check: S_IDLE takes the beat and starts the registered RAM reads,
// S_EXEC registers the result when the output is free; only then is a new beat taken.
// Rebuild: one bitmap read per scan cycle while the stack has room, result via S_RB_END.
// Reset (synchronous, active low) clears the valid flags and sets page count and stack
// top to one; S_INIT writes bitmap and stack entry 0, input ready rises the cycle after.
module page_allocator_bitmap_stack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pgalloc_pkg::t_in_beat i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pgalloc_pkg::t_out_beat o_out_data
);
    import pgalloc_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RB,
        S_RB_END
    } t_state;

    t_state    r_state,     n_state;
    t_cmd      r_cmd,       n_cmd;
    t_page     r_pg,        n_pg;
    t_cnt      r_count,     n_count;
    t_top      r_top,       n_top;
    t_cnt      r_scan,      n_scan;
    t_cnt      r_rb_addr,   n_rb_addr;
    logic      r_rb_vld,    n_rb_vld;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out,       n_out;

    logic       bm_we, bm_re;
    t_addr      bm_waddr, bm_raddr;
    logic [0:0] bm_wdata, bm_rdata;
    logic       st_we, st_re;
    t_sp        st_waddr, st_raddr;
    t_page      st_wdata, st_rdata;

    logic out_free;
    logic pg_out_of_range;
    logic stack_has_room;
    logic rb_issue;

    pgalloc_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_busy_map (
        .i_clk     (i_clk),
        .i_wr_en   (bm_we),
        .i_wr_addr (bm_waddr),
        .i_wr_data (bm_wdata),
        .i_rd_en   (bm_re),
        .i_rd_addr (bm_raddr),
        .o_rd_data (bm_rdata)
    );

    pgalloc_ram #(.WIDTH(PG_W), .DEPTH(STACK_DEPTH)) u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (st_waddr),
        .i_wr_data (st_wdata),
        .i_rd_en   (st_re),
        .i_rd_addr (st_raddr),
        .o_rd_data (st_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign out_free        = !r_out_valid || i_out_ready;
    assign pg_out_of_range = (32'(r_pg) >= 32'(r_count));
    assign stack_has_room  = (r_top < TOP_W'(STACK_DEPTH));
    assign rb_issue        = (r_scan < r_count) && stack_has_room;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pg        = r_pg;
        n_count     = r_count;
        n_top       = r_top;
        n_scan      = r_scan;
        n_rb_addr   = r_rb_addr;
        n_rb_vld    = r_rb_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        bm_we       = 1'b0;
        bm_waddr    = '0;
        bm_wdata    = '0;
        bm_re       = 1'b0;
        bm_raddr    = '0;
        st_we       = 1'b0;
        st_waddr    = '0;
        st_wdata    = '0;
        st_re       = 1'b0;
        st_raddr    = '0;

        case (r_state)
            S_INIT: begin
                bm_we   = 1'b1;
                st_we   = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data.cmd;
                    n_pg  = i_in_data.page_number;
                    if (i_in_data.cmd == CMD_REBUILD) begin
                        n_scan   = '0;
                        n_top    = '0;
                        n_rb_vld = 1'b0;
                        n_state  = S_RB;
                    end else begin
                        bm_re    = 1'b1;
                        bm_raddr = t_addr'(i_in_data.page_number);
                        st_re    = 1'b1;
                        st_raddr = t_sp'(r_top - 1'b1);
                        n_state  = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_page = r_pg;
                    n_out.grew        = 1'b0;
                    n_out.status      = ST_OK;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (r_top != '0) begin
                                n_top             = r_top - 1'b1;
                                n_out.result_page = st_rdata;
                                bm_we             = 1'b1;
                                bm_waddr          = t_addr'(st_rdata);
                                bm_wdata          = 1'b1;
                            end else if (r_count >= CNT_W'(MAX_PAGES)) begin
                                n_out.status      = ST_NO_SPACE;
                                n_out.result_page = '0;
                            end else begin
                                n_count           = r_count + 1'b1;
                                n_out.result_page = PG_W'(r_count);
                                n_out.grew        = 1'b1;
                                bm_we             = 1'b1;
                                bm_waddr          = t_addr'(r_count);
                                bm_wdata          = 1'b1;
                            end
                        end
                        CMD_FREE: begin
                            if (pg_out_of_range) begin
                                n_out.status = ST_NO_PAGE;
                            end else if (!bm_rdata[0]) begin
                                n_out.status = ST_ALREADY_FREE;
                            end else begin
                                bm_we    = 1'b1;
                                bm_waddr = t_addr'(r_pg);
                                bm_wdata = 1'b0;
                                if (stack_has_room) begin
                                    st_we    = 1'b1;
                                    st_waddr = t_sp'(r_top);
                                    st_wdata = r_pg;
                                    n_top    = r_top + 1'b1;
                                end
                            end
                        end
                        CMD_CHECK: begin
                            if (pg_out_of_range || !bm_rdata[0]) begin
                                n_out.status = ST_NO_PAGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            S_RB: begin
                // push the page whose busy bit came back this cycle
                if (r_rb_vld && !bm_rdata[0] && stack_has_room) begin
                    st_we    = 1'b1;
                    st_waddr = t_sp'(r_top);
                    st_wdata = PG_W'(r_rb_addr);
                    n_top    = r_top + 1'b1;
                end
                if (rb_issue) begin
                    bm_re     = 1'b1;
                    bm_raddr  = t_addr'(r_scan);
                    n_rb_addr = r_scan;
                    n_scan    = r_scan + 1'b1;
                    n_rb_vld  = 1'b1;
                end else begin
                    n_rb_vld = 1'b0;
                    if (!r_rb_vld) begin
                        n_state = S_RB_END;
                    end
                end
            end
            S_RB_END: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_page = r_pg;
                    n_out.grew        = 1'b0;
                    n_out.status      = ST_OK;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CNT_W'(1);
            r_top       <= TOP_W'(1);
            r_rb_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_top       <= n_top;
            r_rb_vld    <= n_rb_vld;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_pg      <= n_pg;
        r_scan    <= n_scan;
        r_rb_addr <= n_rb_addr;
        r_out     <= n_out;
    end

endmodule

[hw/rtl/pgalloc_chk.sv]
// Port-level assertions for the page allocator, bound to the top level.
module pgalloc_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input pgalloc_pkg::t_in_beat  i_in_data,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input pgalloc_pkg::t_out_beat o_out_data
);
    import pgalloc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && !$past(i_out_ready))
            |-> (o_out_valid && $stable(o_out_data)))
        else $error("result beat dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command taken while one is in flight");

    a_grew_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.grew) |-> (o_out_data.status == ST_OK))
        else $error("growth reported with non-ok status");

    a_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_NO_SPACE)
            |-> (o_out_data.result_page == '0 && !o_out_data.grew))
        else $error("out-of-space result carries a page");

endmodule

bind page_allocator_bitmap_stack pgalloc_chk u_pgalloc_chk (.*);
